// ===== hdl/tba_pkg.sv =====
// Shared constants and types for the transformed-box bounding-box pipeline.
package tba_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int NUM_PAIRS       = 8;
  localparam int NUM_AXES        = 3;
  localparam int FIELD_W         = 32;
  localparam int PAIR_W          = 64;
  localparam int CFG_IDX_W       = 8;
  localparam int BOX_DATA_W      = 2 * NUM_AXES * FIELD_W;

  localparam logic [PAIR_W-1:0] MAT_RESET [NUM_PAIRS] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

  // Marks the first and last corner of a box as it moves down the pipeline.
  typedef struct packed {
    logic first;
    logic last;
  } corner_tag_t;

endpackage

// ===== hdl/transformed_box_aabb.sv =====
// The corner sequencer issues one corner per cycle, while the pipeline is not held,
// into a shared matrix-multiply stage and three one-bit-per-stage divider lanes;
// a new box is accepted as the last corner of the previous box is issued.
// The whole pipeline holds while a result waits in the output register.
// Reset (rst, synchronous) clears all valid bits and loads the identity matrix.
module transformed_box_aabb import tba_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  input  logic [BOX_DATA_W-1:0] s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // world_min_x, world_min_y, world_min_z, world_max_x, world_max_y, world_max_z
  output logic [BOX_DATA_W-1:0] m_tdata,
  // range_fault
  output logic                  m_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [PAIR_W-1:0]     cfg_data
);

  localparam int SW = 2 * COORD_WIDTH + 2;

  logic [PAIR_W-1:0]             mat [NUM_PAIRS];
  logic                          adv;
  logic                          sum_valid;
  corner_tag_t                   sum_tag;
  logic signed [SW-1:0]          sum_s [4];
  logic                          dv_valid;
  corner_tag_t                   dv_tag;
  logic signed [COORD_WIDTH-1:0] dv_res [NUM_AXES];
  logic [NUM_AXES-1:0]           dv_fault;
  logic signed [COORD_WIDTH-1:0] out_min [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] out_max [NUM_AXES];

  assign cfg_ready = 1'b1;
  assign adv       = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mat <= MAT_RESET;
    end else if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_PAIRS)) begin
      mat[cfg_index[2:0]] <= cfg_data;
    end
  end

  tba_xform #(.CW(COORD_WIDTH), .FB(FRAC_BITS), .SW(SW)) u_xform (
    .clk, .rst, .adv, .s_tvalid, .s_tready, .s_tdata, .mat,
    .sum_valid, .sum_tag, .sum_s
  );

  tba_div #(.CW(COORD_WIDTH), .FB(FRAC_BITS), .SW(SW)) u_div0 (
    .clk, .rst, .adv, .in_valid(sum_valid), .in_tag(sum_tag),
    .num(sum_s[0]), .den(sum_s[3]),
    .out_valid(dv_valid), .out_tag(dv_tag), .out_res(dv_res[0]), .out_fault(dv_fault[0])
  );

  tba_div #(.CW(COORD_WIDTH), .FB(FRAC_BITS), .SW(SW)) u_div1 (
    .clk, .rst, .adv, .in_valid(sum_valid), .in_tag(sum_tag),
    .num(sum_s[1]), .den(sum_s[3]),
    .out_valid(), .out_tag(), .out_res(dv_res[1]), .out_fault(dv_fault[1])
  );

  tba_div #(.CW(COORD_WIDTH), .FB(FRAC_BITS), .SW(SW)) u_div2 (
    .clk, .rst, .adv, .in_valid(sum_valid), .in_tag(sum_tag),
    .num(sum_s[2]), .den(sum_s[3]),
    .out_valid(), .out_tag(), .out_res(dv_res[2]), .out_fault(dv_fault[2])
  );

  tba_reduce #(.CW(COORD_WIDTH)) u_reduce (
    .clk, .rst, .adv, .m_tready, .in_valid(dv_valid), .in_tag(dv_tag),
    .res(dv_res), .fault(dv_fault), .m_tvalid, .out_min, .out_max,
    .out_fault(m_tuser)
  );

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_out
    assign m_tdata[a * FIELD_W +: FIELD_W]              = FIELD_W'(out_min[a]);
    assign m_tdata[(a + NUM_AXES) * FIELD_W +: FIELD_W] = FIELD_W'(out_max[a]);
  end

endmodule

// ===== hdl/tba_xform.sv =====
// Corner sequencer and row-vector times matrix stages.
module tba_xform import tba_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF,
  parameter int SW = 2 * CW + 2
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [BOX_DATA_W-1:0]    s_tdata,
  input  logic [PAIR_W-1:0]        mat [NUM_PAIRS],
  output logic                     sum_valid,
  output corner_tag_t              sum_tag,
  output logic signed [SW-1:0]     sum_s [4]
);

  logic signed [CW-1:0]   box_lo [NUM_AXES];
  logic signed [CW-1:0]   box_hi [NUM_AXES];
  logic                   busy;
  logic [2:0]             cnt;
  logic signed [CW-1:0]   m [4][4];
  logic                   v1, v2;
  corner_tag_t            tag1, tag2;
  logic signed [CW-1:0]   c1 [NUM_AXES];
  logic signed [2*CW-1:0] p2 [NUM_AXES][4];

  assign s_tready = !busy || (adv && cnt == 3'd7);

  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar k = 0; k < 4; k++) begin : g_col
      assign m[r][k] = mat[r * 2 + k / 2][(k % 2) * FIELD_W +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (s_tvalid && s_tready) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (adv && busy) begin
      cnt <= cnt + 3'd1;
      if (cnt == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        box_lo[a] <= s_tdata[a * FIELD_W +: CW];
        box_hi[a] <= s_tdata[(a + NUM_AXES) * FIELD_W +: CW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      sum_valid <= 1'b0;
    end else if (adv) begin
      v1        <= busy;
      v2        <= v1;
      sum_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        c1[a] <= cnt[a] ? box_hi[a] : box_lo[a];
      end
      tag1.first <= (cnt == 3'd0);
      tag1.last  <= (cnt == 3'd7);
      tag2       <= tag1;
      sum_tag    <= tag2;
      for (int r = 0; r < NUM_AXES; r++) begin
        for (int k = 0; k < 4; k++) begin
          p2[r][k] <= c1[r] * m[r][k];
        end
      end
      // Arithmetic right shift rounds each product toward minus infinity.
      for (int k = 0; k < 4; k++) begin
        sum_s[k] <= SW'(m[3][k]) + SW'(p2[0][k] >>> FB) + SW'(p2[1][k] >>> FB)
                  + SW'(p2[2][k] >>> FB);
      end
    end
  end

endmodule

// ===== hdl/tba_div.sv =====
// One lane of the pipelined saturating fixed-point divider, one quotient bit per stage.
module tba_div import tba_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF,
  parameter int SW = 2 * CW + 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  corner_tag_t          in_tag,
  input  logic signed [SW-1:0] num,
  input  logic signed [SW-1:0] den,
  output logic                 out_valid,
  output corner_tag_t          out_tag,
  output logic signed [CW-1:0] out_res,
  output logic                 out_fault
);

  localparam int NW   = SW + FB;
  localparam int TW   = NW - CW;
  localparam int CMPW = (TW > SW) ? TW : SW;

  typedef struct packed {
    logic        neg;
    logic        nneg;
    logic        dz;
    logic        nz;
    logic        ovf;
  } div_flags_t;

  // Stage a: magnitudes.
  logic                va;
  corner_tag_t         taga;
  div_flags_t          fa;
  logic [SW-1:0]       una, uda;

  // Step pipeline, index 0 is the setup stage.
  logic                sv  [CW+1];
  corner_tag_t         stg [CW+1];
  div_flags_t          sf  [CW+1];
  logic [SW-1:0]       sr  [CW+1];
  logic [SW-1:0]       sd  [CW+1];
  logic [CW-1:0]       slb [CW+1];
  logic [CW-1:0]       sq  [CW+1];

  logic [NW-1:0]       dvd;
  logic [CW-1:0]       lim;
  logic                over;

  assign dvd = {una, {FB{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      for (int i = 0; i <= CW; i++) begin
        sv[i] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (adv) begin
      va    <= in_valid;
      sv[0] <= va;
      for (int i = 1; i <= CW; i++) begin
        sv[i] <= sv[i-1];
      end
      out_valid <= sv[CW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      taga    <= in_tag;
      fa.neg  <= num[SW-1] ^ den[SW-1];
      fa.nneg <= num[SW-1];
      fa.dz   <= (den == '0);
      fa.nz   <= (num == '0);
      fa.ovf  <= 1'b0;
      una     <= num[SW-1] ? SW'(-num) : SW'(num);
      uda     <= den[SW-1] ? SW'(-den) : SW'(den);

      stg[0]    <= taga;
      // The quotient fits CW bits only if the high part of the dividend is below the divisor.
      sf[0]     <= {fa.neg, fa.nneg, fa.dz, fa.nz,
                    CMPW'(dvd[NW-1:CW]) >= CMPW'(uda)};
      sr[0]     <= SW'(dvd[NW-1:CW]);
      sd[0]     <= uda;
      slb[0]    <= dvd[CW-1:0];
      sq[0]     <= '0;
    end
  end

  for (genvar i = 1; i <= CW; i++) begin : g_step
    logic [SW:0] r2;
    logic        ge;
    assign r2 = {sr[i-1], slb[i-1][CW-1]};
    assign ge = r2 >= {1'b0, sd[i-1]};
    always_ff @(posedge clk) begin
      if (adv) begin
        stg[i] <= stg[i-1];
        sf[i]  <= sf[i-1];
        sd[i]  <= sd[i-1];
        sr[i]  <= ge ? SW'(r2 - {1'b0, sd[i-1]}) : SW'(r2);
        slb[i] <= slb[i-1] << 1;
        sq[i]  <= {sq[i-1][CW-2:0], ge};
      end
    end
  end

  assign lim  = sf[CW].neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  assign over = sf[CW].ovf || (sq[CW] > lim);

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tag <= stg[CW];
      if (sf[CW].dz) begin
        out_fault <= 1'b1;
        if (sf[CW].nz) begin
          out_res <= '0;
        end else begin
          out_res <= sf[CW].nneg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
      end else if (over) begin
        out_fault <= 1'b1;
        out_res   <= sf[CW].neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
        out_fault <= 1'b0;
        out_res   <= sf[CW].neg ? -sq[CW] : sq[CW];
      end
    end
  end

endmodule

// ===== hdl/tba_reduce.sv =====
// Per-axis min/max accumulation over the eight corners and the output register.
module tba_reduce import tba_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 m_tready,
  input  logic                 in_valid,
  input  corner_tag_t          in_tag,
  input  logic signed [CW-1:0] res [NUM_AXES],
  input  logic [NUM_AXES-1:0]  fault,
  output logic                 m_tvalid,
  output logic signed [CW-1:0] out_min [NUM_AXES],
  output logic signed [CW-1:0] out_max [NUM_AXES],
  output logic                 out_fault
);

  logic signed [CW-1:0] mn [NUM_AXES];
  logic signed [CW-1:0] mx [NUM_AXES];
  logic                 accf;
  logic signed [CW-1:0] mn_next [NUM_AXES];
  logic signed [CW-1:0] mx_next [NUM_AXES];
  logic                 accf_next;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      mn_next[a] = (in_tag.first || res[a] < mn[a]) ? res[a] : mn[a];
      mx_next[a] = (in_tag.first || res[a] > mx[a]) ? res[a] : mx[a];
    end
    accf_next = (!in_tag.first && accf) || (|fault);
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      mn   <= mn_next;
      mx   <= mx_next;
      accf <= accf_next;
      if (in_tag.last) begin
        out_min   <= mn_next;
        out_max   <= mx_next;
        out_fault <= accf_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv && in_valid && in_tag.last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

// ===== hdl/tba_check.sv =====
// Port-level checker for the bounding-box block, bound to the top level.
module tba_check import tba_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [BOX_DATA_W-1:0] m_tdata
);

  logic signed [FIELD_W-1:0] mn [NUM_AXES];
  logic signed [FIELD_W-1:0] mx [NUM_AXES];
  logic                      ordered;

  always_comb begin
    ordered = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      mn[a] = m_tdata[a * FIELD_W +: FIELD_W];
      mx[a] = m_tdata[(a + NUM_AXES) * FIELD_W +: FIELD_W];
      if (mn[a] > mx[a]) begin
        ordered = 1'b0;
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result transaction changed while stalled");

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_ordered: assert property (@(posedge clk) disable iff (rst) m_tvalid |-> ordered)
    else $error("world minimum above maximum");

  a_one_box: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second box taken before its corners were issued");

endmodule

bind transformed_box_aabb tba_check u_check (.*);

// ===== verif/transformed_box_aabb_test.sv =====
// Self-checking testbench for the transformed-box bounding-box unit.
`timescale 1ns / 1ps

module transformed_box_aabb_test;
  import tba_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int LATENCY = CW + 14;

  typedef struct packed {
    logic [FIELD_W-1:0] mx_z, mx_y, mx_x, mn_z, mn_y, mn_x;
  } box_t;

  typedef struct {
    box_t bounds;
    logic fault;
  } aabb_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [BOX_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [BOX_DATA_W-1:0] m_tdata;
  logic m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PAIR_W-1:0] cfg_data = '0;

  transformed_box_aabb u_top (.*);

  always #5 clk = ~clk;

  logic [PAIR_W-1:0] matrix_regs [NUM_PAIRS];
  aabb_t expected_aabbs [$];
  int errors = 0;
  int hold_off_cycles = 0;
  bit drain_rx = 1'b0;

  function automatic longint sx(logic [31:0] v);
    return longint'(signed'(v[CW-1:0]));
  endfunction

  function automatic longint mat_entry(int row, int col);
    logic [PAIR_W-1:0] r;
    r = matrix_regs[row * 2 + col / 2];
    return (col % 2) ? sx(r[63:32]) : sx(r[31:0]);
  endfunction

  function automatic longint floor_q(longint p);
    return p >>> FB;
  endfunction

  function automatic longint sat_to(bit neg);
    return neg ? -(longint'(1) << (CW - 1)) : (longint'(1) << (CW - 1)) - 1;
  endfunction

  // Quotient (n << FB) / d truncated toward zero, saturated to the coordinate range.
  function automatic longint project_div(longint n, longint d, inout bit fault);
    bit neg;
    logic [63:0] un, ud, q, r, limit, mag;
    if (d == 0) begin
      fault = 1'b1;
      if (n == 0) return 0;
      return sat_to(n < 0);
    end
    neg = (n < 0) != (d < 0);
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    if (un == 0) return 0;
    limit = (64'd1 << (CW - 1)) - (neg ? 0 : 1);
    q = un / ud;
    r = un % ud;
    if (q > (limit >> FB)) begin
      fault = 1'b1;
      return sat_to(neg);
    end
    mag = q << FB;
    for (int i = FB - 1; i >= 0; i--) begin
      r = r << 1;
      if (r >= ud) begin
        r -= ud;
        mag[i] = 1'b1;
      end
    end
    if (mag > limit) begin
      fault = 1'b1;
      return sat_to(neg);
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic aabb_t world_aabb(box_t b);
    longint lo [3], hi [3], mn [3], mx [3], v [3], s [4], res;
    aabb_t out;
    bit fault;
    fault = 1'b0;
    lo = '{sx(b.mn_x), sx(b.mn_y), sx(b.mn_z)};
    hi = '{sx(b.mx_x), sx(b.mx_y), sx(b.mx_z)};
    for (int c = 0; c < 8; c++) begin
      for (int a = 0; a < 3; a++) v[a] = c[a] ? hi[a] : lo[a];
      for (int k = 0; k < 4; k++) begin
        s[k] = mat_entry(3, k);
        for (int r = 0; r < 3; r++) s[k] += floor_q(v[r] * mat_entry(r, k));
      end
      for (int a = 0; a < 3; a++) begin
        res = project_div(s[a], s[3], fault);
        if (c == 0 || res < mn[a]) mn[a] = res;
        if (c == 0 || res > mx[a]) mx[a] = res;
      end
    end
    out.bounds = {mx[2][31:0], mx[1][31:0], mx[0][31:0],
                  mn[2][31:0], mn[1][31:0], mn[0][31:0]};
    out.fault = fault;
    return out;
  endfunction

  // The valid line stays high after a transaction so that the next box can follow
  // without a gap; wait_idle drops it.
  task automatic send_box(box_t b, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15));
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    expected_aabbs.push_back(world_aabb(b));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_aabbs.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [PAIR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_PAIRS) matrix_regs[idx] = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] q16(int whole);
    return 32'(whole) << FB;
  endfunction

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 2000)) - 1000) << ($urandom_range(8, 16));
    endcase
  endfunction

  function automatic box_t rand_box();
    box_t b;
    int mode;
    mode = $urandom_range(0, 9) < 2 ? $urandom_range(0, 1) : 2;
    b = {rand_coord(mode), rand_coord(mode), rand_coord(mode),
         rand_coord(mode), rand_coord(mode), rand_coord(mode)};
    return b;
  endfunction

  function automatic logic [PAIR_W-1:0] rand_pair();
    logic [31:0] h [2];
    for (int i = 0; i < 2; i++)
      case ($urandom_range(0, 5))
        0: h[i] = $urandom();
        1: h[i] = 0;
        default: h[i] = 32'($signed($urandom_range(0, 8)) - 4) << $urandom_range(12, 17);
      endcase
    return {h[1], h[0]};
  endfunction

  task automatic load_matrix(logic [PAIR_W-1:0] m [NUM_PAIRS]);
    for (int i = 0; i < NUM_PAIRS; i++) write_reg(i, m[i]);
  endtask

  task automatic test_identity_extremes();
    box_t b;
    send_box('0);
    send_box({q16(1), q16(2), q16(3), -q16(1), -q16(2), -q16(3)});
    send_box({6{32'h7FFF_FFFF}});
    send_box({6{32'h8000_0000}});
    send_box({{3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}});
    send_box({{3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}});
    // Swapped corners: minimum above maximum.
    send_box({-q16(5), -q16(4), -q16(3), q16(5), q16(4), q16(3)});
    send_box({6{32'hFFFF_FFFF}});
    send_box({6{32'h5555_5555}});
    send_box({6{32'hAAAA_AAAA}});
    wait_idle();
  endtask

  task automatic test_zero_w();
    logic [PAIR_W-1:0] m [NUM_PAIRS];
    m = MAT_RESET;
    m[7] = 64'h0;
    load_matrix(m);
    send_box('0);
    send_box({q16(1), q16(1), q16(1), -q16(1), -q16(1), -q16(1)});
    send_box({q16(2), q16(0), -q16(2), q16(2), q16(0), -q16(2)});
    wait_idle();
    // w depends on z: the z = -1 corner hits zero w.
    m = MAT_RESET;
    m[5] = {q16(1), q16(1)};
    load_matrix(m);
    send_box({q16(3), q16(3), q16(3), -q16(1), q16(1), q16(1)});
    wait_idle();
  endtask

  task automatic test_overflow();
    logic [PAIR_W-1:0] m [NUM_PAIRS];
    m = '{64'h7FFF_FFFF_7FFF_FFFF, 64'h8000_0000_8000_0000, {32'h0, 32'h7FFF_FFFF},
          64'h8000_0000_7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0001_8000_0000,
          64'h7FFF_FFFF_8000_0000, 64'h0000_0001_0000_0000};
    load_matrix(m);
    send_box({q16(1), q16(1), q16(1), q16(0), q16(0), q16(0)});
    send_box({6{32'h7FFF_FFFF}});
    send_box({{3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}});
    wait_idle();
    // Small w gives huge quotients.
    m = MAT_RESET;
    m[7] = {32'h0000_0001, 32'h0};
    load_matrix(m);
    send_box({q16(1), q16(1), q16(1), -q16(1), -q16(1), -q16(1)});
    wait_idle();
    write_reg(NUM_PAIRS + 3, 64'hDEAD_BEEF_DEAD_BEEF);
  endtask

  task automatic test_random(int count);
    logic [PAIR_W-1:0] m [NUM_PAIRS];
    for (int p = 0; p < 8; p++) begin
      m = MAT_RESET;
      for (int i = 0; i < NUM_PAIRS; i++)
        if ($urandom_range(0, 1)) m[i] = rand_pair();
      // Keep w mostly away from zero so most boxes project cleanly.
      if (p % 2 == 0) m[7] = {q16($urandom_range(1, 3)), m[7][31:0]};
      load_matrix(m);
      for (int n = 0; n < count / 8; n++) send_box(rand_box());
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    load_matrix(MAT_RESET);
    hold_off_cycles = 400;
    for (int n = 0; n < 30; n++) send_box(rand_box(), 1);
    wait_idle();
    // Burst with a sender pause until everything drains.
    for (int n = 0; n < 10; n++) send_box(rand_box(), 1);
    wait_idle();
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        m_tready <= 1'b0;
        hold_off_cycles--;
      end else if (m_tvalid && m_tready) begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
          m_tready <= 1'b1;
        end
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    aabb_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_aabbs.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_tdata);
        errors++;
      end else begin
        exp_r = expected_aabbs.pop_front();
        if (m_tdata !== exp_r.bounds) begin
          $display("%0t: bounds expected %h actual %h", $time, exp_r.bounds, m_tdata);
          errors++;
        end
        if (m_tuser !== exp_r.fault) begin
          $display("%0t: range_fault expected %b actual %b", $time, exp_r.fault, m_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    matrix_regs = MAT_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_identity_extremes();
    test_zero_w();
    test_overflow();
    test_backpressure();
    test_random(880);
    wait_idle();
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
